/* design/linear_probe_hash_table_macros.svh */
// Assertion macros used by the hash table back end.
`ifndef LINEAR_PROBE_HASH_TABLE_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_MACROS_SVH

// Same-cycle implication, clocked on clk_i, off during reset
`define LPHT_ASSERT_NOW(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off during reset
`define LPHT_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error(msg);

`endif

/* design/lpht_pkg.sv */
// Shared types and constants of the linear probe hash table.
`timescale 1ns / 1ps
`default_nettype none

package lpht_pkg;

  localparam int KEY_W      = 32;
  localparam int DATA_W     = 32;
  localparam int CNT_W      = 32;
  localparam int TBITS_W    = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;

  localparam logic [KEY_W-1:0]     FIB_MULT       = 32'h9E37_79B9;
  localparam logic [TBITS_W-1:0]   TBITS_RESET    = 4'd10;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_FIB    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_BITS = 1'd1;

  typedef enum logic [1:0] {
    OP_SEARCH = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_FOUND     = 3'd0,
    ST_INSERTED  = 3'd1,
    ST_REMOVED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4,
    ST_CLEARED   = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    BK_INIT,
    BK_IDLE,
    BK_PROBE,
    BK_CLEAR
  } back_state_e;

  // Live configuration as seen by front and back
  typedef struct packed {
    logic               use_fib;
    logic [TBITS_W-1:0] live_bits;
  } cfg_t;

endpackage

`default_nettype wire

/* design/lpht_fifo.sv */
// Small register queue between the front and back of the hash table.
`timescale 1ns / 1ps
`default_nettype none

module lpht_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_valid_i,
  output      logic             push_ready_o,
  input  wire logic [WIDTH-1:0] push_data_i,
  output      logic             pop_valid_o,
  input  wire logic             pop_i,
  output      logic [WIDTH-1:0] pop_data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LastPtr = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FullCnt = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign push_ready_o = (cnt_q != FullCnt);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

/* design/lpht_front.sv */
// Front end: takes input words, hashes the key and queues the job.
`timescale 1ns / 1ps
`default_nettype none

module lpht_front #(
  parameter int SLOT_BITS = 10,
  parameter int STORE_W   = 32,
  parameter int ENTRY_W   = 2 + 32 + STORE_W + SLOT_BITS
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire lpht_pkg::cfg_t                   cfg_i,
  input  wire logic                             init_busy_i,
  input  wire logic                             in_valid_i,
  output      logic                             in_ready_o,
  input  wire logic [1:0]                       operation_i,
  input  wire logic [lpht_pkg::KEY_W-1:0]       lookup_key_i,
  input  wire logic [lpht_pkg::DATA_W-1:0]      write_data_i,
  output      logic                             push_valid_o,
  input  wire logic                             push_ready_i,
  output      logic [ENTRY_W-1:0]               push_data_o
);

  logic                          stg_valid_q, stg_valid_d;
  logic [1:0]                    stg_op_q;
  logic [lpht_pkg::KEY_W-1:0]    stg_key_q;
  logic [STORE_W-1:0]            stg_data_q;
  logic [lpht_pkg::KEY_W-1:0]    stg_prod_q;
  logic                          accept;
  logic [5:0]                    fib_shift;
  logic [lpht_pkg::KEY_W-1:0]    fib_home, mask_home, low_mask;
  logic [SLOT_BITS-1:0]          home;

  assign in_ready_o   = !init_busy_i && (!stg_valid_q || push_ready_i);
  assign accept       = in_valid_i && in_ready_o;
  assign push_valid_o = stg_valid_q;

  // home slot from the registered product or the key's low bits
  assign fib_shift = 6'd32 - {2'b00, cfg_i.live_bits};
  assign fib_home  = stg_prod_q >> fib_shift;
  assign low_mask  = (32'd1 << cfg_i.live_bits) - 32'd1;
  assign mask_home = stg_key_q & low_mask;
  assign home      = cfg_i.use_fib ? fib_home[SLOT_BITS-1:0] : mask_home[SLOT_BITS-1:0];

  assign push_data_o = {stg_op_q, stg_key_q, stg_data_q, home};

  always_comb begin
    stg_valid_d = stg_valid_q;
    if (accept) begin
      stg_valid_d = 1'b1;
    end else if (push_ready_i) begin
      stg_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else begin
      stg_valid_q <= stg_valid_d;
    end
  end

  // stage payload; the multiply result is registered here
  always_ff @(posedge clk_i) begin
    if (accept) begin
      stg_op_q   <= operation_i;
      stg_key_q  <= lookup_key_i;
      stg_data_q <= write_data_i[STORE_W-1:0];
      stg_prod_q <= lookup_key_i * lpht_pkg::FIB_MULT;
    end
  end

endmodule

`default_nettype wire

/* design/lpht_back.sv */
// Back end: probe sequencer over the slot and collision counter memories.
`timescale 1ns / 1ps
`default_nettype none
`include "linear_probe_hash_table_macros.svh"

module lpht_back #(
  parameter int SLOT_BITS = 10,
  parameter int STORE_W   = 32,
  parameter int ENTRY_W   = 2 + 32 + STORE_W + SLOT_BITS
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire lpht_pkg::cfg_t               cfg_i,
  output      logic                         init_busy_o,
  input  wire logic                         q_valid_i,
  output      logic                         pop_o,
  input  wire logic [ENTRY_W-1:0]           q_data_i,
  output      logic                         out_valid_o,
  input  wire logic                         out_ready_i,
  output      logic [2:0]                   status_o,
  output      logic [lpht_pkg::DATA_W-1:0]  read_data_o,
  output      logic [SLOT_BITS-1:0]         home_slot_o,
  output      logic [SLOT_BITS:0]           probe_steps_o,
  output      logic [lpht_pkg::CNT_W-1:0]   home_collisions_o
);

  localparam int NUM    = 1 << SLOT_BITS;
  localparam int KW     = lpht_pkg::KEY_W;
  localparam int CW     = lpht_pkg::CNT_W;
  localparam int SW     = 1 + KW + STORE_W;
  localparam int H_LO   = 0;
  localparam int D_LO   = SLOT_BITS;
  localparam int K_LO   = SLOT_BITS + STORE_W;
  localparam int O_LO   = SLOT_BITS + STORE_W + KW;

  lpht_pkg::back_state_e state_q, state_d;

  // slot word: {used, key, value}
  logic [SW-1:0]         slot_mem [NUM];
  logic [CW-1:0]         coll_mem [NUM];
  logic [SW-1:0]         slot_rd_q;
  logic [CW-1:0]         coll_rd_q;
  logic                  slot_re, slot_we, coll_re, coll_we;
  logic [SLOT_BITS-1:0]  slot_raddr, slot_waddr, coll_raddr, coll_waddr;
  logic [SW-1:0]         slot_wdata;
  logic [CW-1:0]         coll_wdata;

  // job registers
  logic [1:0]            op_q, op_d;
  logic [KW-1:0]         key_q, key_d;
  logic [STORE_W-1:0]    data_q, data_d;
  logic [SLOT_BITS-1:0]  home_q, home_d, idx_q, idx_d, sweep_q, sweep_d;
  logic [SLOT_BITS:0]    steps_q, steps_d;

  // output register
  logic                  out_valid_q, out_valid_d, load;
  logic [2:0]            status_q, status_d;
  logic [lpht_pkg::DATA_W-1:0] rdata_q, rdata_d;
  logic [SLOT_BITS-1:0]  hout_q;
  logic [SLOT_BITS:0]    sout_q, sout_d;
  logic [CW-1:0]         hcoll_q, hcoll_d;

  logic                  out_free;
  logic [SLOT_BITS:0]    size, step_next, steps_fin;
  logic [SLOT_BITS-1:0]  wrap_mask;
  logic                  s_used, is_free, is_hit, swept, final_step;
  logic [KW-1:0]         s_key;
  logic [STORE_W-1:0]    s_val;
  logic [CW:0]           coll_sum;
  logic [CW-1:0]         coll_new;

  assign init_busy_o = (state_q == lpht_pkg::BK_INIT);
  assign out_free    = !out_valid_q || out_ready_i;

  // probe bookkeeping
  assign size       = (SLOT_BITS + 1)'(1) << cfg_i.live_bits;
  assign wrap_mask  = SLOT_BITS'(size - (SLOT_BITS + 1)'(1));
  assign s_used     = slot_rd_q[SW-1];
  assign s_key      = slot_rd_q[STORE_W +: KW];
  assign s_val      = slot_rd_q[STORE_W-1:0];
  assign is_free    = !s_used;
  assign is_hit     = s_used && (s_key == key_q);
  assign step_next  = steps_q + (SLOT_BITS + 1)'(1);
  assign swept      = !is_free && !is_hit && (step_next == size);
  assign final_step = is_free || is_hit || swept;
  assign steps_fin  = swept ? step_next : steps_q;

  // saturating counter update, one add for the whole walk
  assign coll_sum = {1'b0, coll_rd_q} + (CW + 1)'(steps_fin);
  assign coll_new = coll_sum[CW] ? {CW{1'b1}} : coll_sum[CW-1:0];

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    key_d       = key_q;
    data_d      = data_q;
    home_d      = home_q;
    idx_d       = idx_q;
    steps_d     = steps_q;
    sweep_d     = sweep_q;
    pop_o       = 1'b0;
    slot_re     = 1'b0;
    slot_raddr  = idx_q;
    coll_re     = 1'b0;
    coll_raddr  = home_q;
    slot_we     = 1'b0;
    slot_waddr  = idx_q;
    slot_wdata  = {1'b1, key_q, data_q};
    coll_we     = 1'b0;
    coll_waddr  = home_q;
    coll_wdata  = coll_new;
    load        = 1'b0;
    status_d    = lpht_pkg::ST_NOT_FOUND;
    rdata_d     = '0;
    sout_d      = steps_fin;
    hcoll_d     = coll_new;

    case (state_q)
      // clearing pass after reset: empty every slot, zero every counter
      lpht_pkg::BK_INIT: begin
        slot_we    = 1'b1;
        slot_waddr = sweep_q;
        slot_wdata = '0;
        coll_we    = 1'b1;
        coll_waddr = sweep_q;
        coll_wdata = '0;
        sweep_d    = sweep_q + SLOT_BITS'(1);
        if (&sweep_q) begin
          state_d = lpht_pkg::BK_IDLE;
        end
      end

      // take the next job; unless it is a clear, start the first slot read at home
      lpht_pkg::BK_IDLE: begin
        if (q_valid_i) begin
          pop_o   = 1'b1;
          op_d    = q_data_i[O_LO +: 2];
          key_d   = q_data_i[K_LO +: KW];
          data_d  = q_data_i[D_LO +: STORE_W];
          home_d  = q_data_i[H_LO +: SLOT_BITS];
          idx_d   = q_data_i[H_LO +: SLOT_BITS];
          steps_d = '0;
          if (lpht_pkg::op_e'(q_data_i[O_LO +: 2]) == lpht_pkg::OP_CLEAR) begin
            state_d = lpht_pkg::BK_CLEAR;
          end else begin
            slot_re    = 1'b1;
            slot_raddr = q_data_i[H_LO +: SLOT_BITS];
            coll_re    = 1'b1;
            coll_raddr = q_data_i[H_LO +: SLOT_BITS];
            state_d    = lpht_pkg::BK_PROBE;
          end
        end
      end

      // one slot per cycle; stall in place on the last one until output frees
      lpht_pkg::BK_PROBE: begin
        if (!final_step) begin
          steps_d    = step_next;
          idx_d      = (idx_q + SLOT_BITS'(1)) & wrap_mask;
          slot_re    = 1'b1;
          slot_raddr = (idx_q + SLOT_BITS'(1)) & wrap_mask;
        end else if (out_free) begin
          load    = 1'b1;
          coll_we = 1'b1;
          state_d = lpht_pkg::BK_IDLE;
          case (lpht_pkg::op_e'(op_q))
            lpht_pkg::OP_SEARCH: begin
              if (is_hit) begin
                status_d = lpht_pkg::ST_FOUND;
                rdata_d  = lpht_pkg::DATA_W'(s_val);
              end
            end
            lpht_pkg::OP_INSERT: begin
              if (is_hit) begin
                slot_we  = 1'b1;
                status_d = lpht_pkg::ST_FOUND;
              end else if (is_free) begin
                slot_we  = 1'b1;
                status_d = lpht_pkg::ST_INSERTED;
              end else begin
                status_d = lpht_pkg::ST_FULL;
              end
            end
            lpht_pkg::OP_REMOVE: begin
              if (is_hit) begin
                slot_we    = 1'b1;
                slot_wdata = '0;
                status_d   = lpht_pkg::ST_REMOVED;
              end
            end
            default: begin
              status_d = lpht_pkg::ST_NOT_FOUND;
            end
          endcase
        end
      end

      // zero every counter, one per cycle, then report
      lpht_pkg::BK_CLEAR: begin
        coll_we    = 1'b1;
        coll_waddr = sweep_q;
        coll_wdata = '0;
        status_d   = lpht_pkg::ST_CLEARED;
        sout_d     = '0;
        hcoll_d    = '0;
        if (!(&sweep_q)) begin
          sweep_d = sweep_q + SLOT_BITS'(1);
        end else if (out_free) begin
          load    = 1'b1;
          sweep_d = '0;
          state_d = lpht_pkg::BK_IDLE;
        end
      end

      default: begin
        state_d = lpht_pkg::BK_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lpht_pkg::BK_INIT;
      sweep_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      out_valid_q <= out_valid_d;
    end
  end

  // job and result payload
  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    key_q   <= key_d;
    data_q  <= data_d;
    home_q  <= home_d;
    idx_q   <= idx_d;
    steps_q <= steps_d;
    if (load) begin
      status_q <= status_d;
      rdata_q  <= rdata_d;
      hout_q   <= home_q;
      sout_q   <= sout_d;
      hcoll_q  <= hcoll_d;
    end
  end

  // slot memory, registered read
  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    if (slot_re) begin
      slot_rd_q <= slot_mem[slot_raddr];
    end
  end

  // collision counter memory, registered read
  always_ff @(posedge clk_i) begin
    if (coll_we) begin
      coll_mem[coll_waddr] <= coll_wdata;
    end
    if (coll_re) begin
      coll_rd_q <= coll_mem[coll_raddr];
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = status_q;
  assign read_data_o       = rdata_q;
  assign home_slot_o       = hout_q;
  assign probe_steps_o     = sout_q;
  assign home_collisions_o = hcoll_q;

  `LPHT_ASSERT_NOW(a_no_pop_in_init, state_q == lpht_pkg::BK_INIT, !pop_o, "job taken during clearing pass")
  `LPHT_ASSERT_NOW(a_steps_bound, state_q == lpht_pkg::BK_PROBE, steps_q < size, "probe ran past table size")
  `LPHT_ASSERT_NEXT(a_clear_result, load && state_q == lpht_pkg::BK_CLEAR, hcoll_q == '0 && status_q == lpht_pkg::ST_CLEARED, "clear result wrong")

endmodule

`default_nettype wire

/* design/linear_probe_hash_table.sv */
// Top level of the linear probe hash table: config registers, front, queue, back.
//
//   channel | signals                                  | direction
//   --------+------------------------------------------+----------
//   in      | in_valid_i/in_ready_o, operation_i,      | input
//           | lookup_key_i, write_data_i               |
//   out     | out_valid_o/out_ready_i, status_o,       | output
//           | read_data_o, home_slot_o, probe_steps_o, |
//           | home_collisions_o                        |
//   cfg     | cfg_we_i, cfg_index_i, cfg_wdata_i       | input
//
// Search, insert and remove probe from the home slot on until a hit, a free slot or a
// full sweep; the back reads one slot per cycle from its single-port slot RAM.
// Clearing the collision counters zeroes one counter per cycle.
// After reset a clearing pass empties every slot and counter; in_ready_o stays low meanwhile.
// The front keeps accepting into its stage and a two-word queue while the back probes;
// a finished result waits in the output register; the next probe stalls only at its last slot.
`timescale 1ns / 1ps
`default_nettype none

module linear_probe_hash_table #(
  parameter int SLOT_BITS  = 10,
  parameter int VALUE_BITS = 32
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [lpht_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [lpht_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  wire logic                                 in_valid_i,
  output      logic                                 in_ready_o,
  input  wire logic [1:0]                           operation_i,
  input  wire logic [lpht_pkg::KEY_W-1:0]           lookup_key_i,
  input  wire logic [lpht_pkg::DATA_W-1:0]          write_data_i,
  output      logic                                 out_valid_o,
  input  wire logic                                 out_ready_i,
  output      logic [2:0]                           status_o,
  output      logic [lpht_pkg::DATA_W-1:0]          read_data_o,
  output      logic [SLOT_BITS-1:0]                 home_slot_o,
  output      logic [SLOT_BITS:0]                   probe_steps_o,
  output      logic [lpht_pkg::CNT_W-1:0]           home_collisions_o
);

  localparam int STORE_W = (VALUE_BITS < lpht_pkg::DATA_W) ? VALUE_BITS : lpht_pkg::DATA_W;
  localparam int ENTRY_W = 2 + lpht_pkg::KEY_W + STORE_W + SLOT_BITS;
  localparam logic [lpht_pkg::TBITS_W:0] SlotBitsW = (lpht_pkg::TBITS_W + 1)'(SLOT_BITS);

  logic                          use_fib_q;
  logic [lpht_pkg::TBITS_W-1:0]  tbits_q, live_bits;
  lpht_pkg::cfg_t                cfg;
  logic                          init_busy;
  logic                          push_valid, push_ready, pop_valid, pop;
  logic [ENTRY_W-1:0]            push_data, pop_data;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_fib_q <= 1'b1;
      tbits_q   <= lpht_pkg::TBITS_RESET;
    end else if (cfg_we_i) begin
      if (cfg_index_i == lpht_pkg::CFG_USE_FIB) begin
        use_fib_q <= cfg_wdata_i[0];
      end else if (cfg_index_i == lpht_pkg::CFG_TABLE_BITS) begin
        tbits_q <= cfg_wdata_i[lpht_pkg::TBITS_W-1:0];
      end
    end
  end

  // table size in use: zero acts as one, clamp at the built size
  always_comb begin
    live_bits = tbits_q;
    if (tbits_q == '0) begin
      live_bits = lpht_pkg::TBITS_W'(1);
    end else if ({1'b0, tbits_q} > SlotBitsW) begin
      live_bits = SlotBitsW[lpht_pkg::TBITS_W-1:0];
    end
  end

  assign cfg.use_fib   = use_fib_q;
  assign cfg.live_bits = live_bits;

  lpht_front #(
    .SLOT_BITS (SLOT_BITS),
    .STORE_W   (STORE_W),
    .ENTRY_W   (ENTRY_W)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .init_busy_i  (init_busy),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .operation_i  (operation_i),
    .lookup_key_i (lookup_key_i),
    .write_data_i (write_data_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  lpht_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (2)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_data_o   (pop_data)
  );

  lpht_back #(
    .SLOT_BITS (SLOT_BITS),
    .STORE_W   (STORE_W),
    .ENTRY_W   (ENTRY_W)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg),
    .init_busy_o       (init_busy),
    .q_valid_i         (pop_valid),
    .pop_o             (pop),
    .q_data_i          (pop_data),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .status_o          (status_o),
    .read_data_o       (read_data_o),
    .home_slot_o       (home_slot_o),
    .probe_steps_o     (probe_steps_o),
    .home_collisions_o (home_collisions_o)
  );

endmodule

`default_nettype wire
